// File: rtl/lda_pkg.sv
// Shared widths, mode codes and control types of the least-demanded allocator.
package lda_pkg;

  // Field widths fixed by the word formats
  localparam int MODE_W = 2;
  localparam int IDX_W  = 8;
  localparam int SIZE_W = 9;

  // Pool size after reset
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;

  // Input mode codes
  localparam logic [MODE_W-1:0] MODE_ENTRY = 2'd0;
  localparam logic [MODE_W-1:0] MODE_EMPTY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Control from the sequencer to the minimum tracker
  typedef struct packed {
    logic clr;   // restart the search
    logic take;  // current entry is a candidate
  } scan_ctl_t;

endpackage

// File: rtl/lda_if.sv
// Channel interfaces: request words, grant words and the pool size write port.
interface lda_in_if;
  logic                       valid;
  logic                       ready;
  logic [lda_pkg::MODE_W-1:0] mode;
  logic [lda_pkg::IDX_W-1:0]  resource_index;
  logic                       last_entry;

  modport source (output valid, mode, resource_index, last_entry, input ready);
  modport sink   (input valid, mode, resource_index, last_entry, output ready);
endinterface

interface lda_out_if;
  logic                      valid;
  logic                      ready;
  logic [lda_pkg::IDX_W-1:0] granted_index;
  logic                      none_available;
  logic                      index_ignored;

  modport source (output valid, granted_index, none_available, index_ignored, input ready);
  modport sink   (input valid, granted_index, none_available, index_ignored, output ready);
endinterface

interface lda_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [lda_pkg::SIZE_W-1:0] pool_size;

  modport source (output valid, pool_size, input ready);
  modport sink   (input valid, pool_size, output ready);
endinterface

// File: rtl/lda_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module lda_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/lda_scan.sv
// Running minimum tracker: keeps the lowest count seen and its address.
module lda_scan #(
  parameter int AW = 8,
  parameter int CW = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  lda_pkg::scan_ctl_t ctl,
  input  logic [AW-1:0]      addr,
  input  logic [CW-1:0]      count,
  output logic               found,
  output logic [AW-1:0]      best_addr,
  output logic [CW-1:0]      best_count
);

  logic          found_r;
  logic [AW-1:0] best_addr_r;
  logic [CW-1:0] best_count_r;
  logic          better;

  // Strictly lower wins, so ties keep the lower address seen first
  assign better = ctl.take && (!found_r || (count < best_count_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (ctl.clr) begin
      found_r <= 1'b0;
    end else if (better) begin
      found_r <= 1'b1;
    end
  end

  // Hold best candidate
  always_ff @(posedge clk) begin
    if (!ctl.clr && better) begin
      best_addr_r  <= addr;
      best_count_r <= count;
    end
  end

  assign found      = found_r;
  assign best_addr  = best_addr_r;
  assign best_count = best_count_r;

endmodule

// File: rtl/least_demanded_item_allocator.sv
// Top level: request counting, grant scan over the pool memory and result register.
//
//   channel  dir  handshake     word
//   in_ch    in   valid/ready   mode, resource_index, last_entry
//   out_ch   out  valid/ready   granted_index, none_available, index_ignored
//   cfg_ch   in   valid/ready   pool_size (ready always high)
//
// An entry reads its pool memory entry, then writes back the raised count.
// Closing a request walks every entry of the pool memory once through its single
// read port (clearing acceptable marks), then the grant is written.
// After reset and on a clear word a clearing pass over every entry holds in_ch off.
// The result register frees the input side; only a grant waits for a taken result.
module least_demanded_item_allocator #(
  parameter int POOL_DEPTH  = 256,
  parameter int COUNT_WIDTH = 9
) (
  input logic         clk,
  input logic         rst_n,
  lda_in_if.sink      in_ch,
  lda_out_if.source   out_ch,
  lda_cfg_if.sink     cfg_ch
);

  localparam int AW    = $clog2(POOL_DEPTH);
  localparam int EW    = COUNT_WIDTH + 2;
  localparam int CNT_W = AW + 1;
  localparam int CMP_W = (AW > lda_pkg::SIZE_W) ? AW : lda_pkg::SIZE_W;

  typedef enum logic [4:0] {
    ST_CLR   = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_UPD   = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_GRANT = 5'b10000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [CNT_W-1:0]            clr_cnt_r, clr_cnt_nxt;
  logic [CNT_W-1:0]            scan_cnt_r, scan_cnt_nxt;
  logic [AW-1:0]               upd_addr_r, upd_addr_nxt;
  logic                        upd_ok_r, upd_ok_nxt;
  logic                        upd_last_r, upd_last_nxt;
  logic                        chk_vld_r, chk_vld_nxt;
  logic [AW-1:0]               chk_addr_r, chk_addr_nxt;
  logic                        ignored_r, ignored_nxt;
  logic [lda_pkg::SIZE_W-1:0]  pool_size_r;
  logic                        out_vld_r, out_vld_nxt;
  logic [lda_pkg::IDX_W-1:0]   out_idx_r, out_idx_nxt;
  logic                        out_none_r, out_none_nxt;
  logic                        out_ign_r, out_ign_nxt;

  logic                        ram_we, ram_re;
  logic [AW-1:0]               ram_waddr, ram_raddr;
  logic [EW-1:0]               ram_wdata, ram_rdata;
  logic [COUNT_WIDTH-1:0]      rd_count;
  logic                        rd_granted, rd_acc;
  logic [COUNT_WIDTH-1:0]      cnt_inc;

  lda_pkg::scan_ctl_t          scan_ctl;
  logic                        best_found;
  logic [AW-1:0]               best_addr;
  logic [COUNT_WIDTH-1:0]      best_count;

  logic                        in_acc;
  logic                        in_range;
  logic                        chk_in_range;

  // Entry layout: {count, granted, acceptable}
  assign rd_count   = ram_rdata[EW-1:2];
  assign rd_granted = ram_rdata[1];
  assign rd_acc     = ram_rdata[0];
  assign cnt_inc    = (&rd_count) ? rd_count : rd_count + 1'b1;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign in_acc       = in_ch.valid && in_ch.ready;

  assign in_range = (32'(in_ch.resource_index) < 32'(pool_size_r)) &&
                    (32'(in_ch.resource_index) < POOL_DEPTH);
  assign chk_in_range = (CMP_W'(chk_addr_r) < CMP_W'(pool_size_r));

  lda_ram #(
    .WIDTH (EW),
    .DEPTH (POOL_DEPTH)
  ) u_pool_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  lda_scan #(
    .AW (AW),
    .CW (COUNT_WIDTH)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (scan_ctl),
    .addr       (chk_addr_r),
    .count      (rd_count),
    .found      (best_found),
    .best_addr  (best_addr),
    .best_count (best_count)
  );

  // Sequencer: memory accesses and next state
  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    scan_cnt_nxt = scan_cnt_r;
    upd_addr_nxt = upd_addr_r;
    upd_ok_nxt   = upd_ok_r;
    upd_last_nxt = upd_last_r;
    chk_vld_nxt  = chk_vld_r;
    chk_addr_nxt = chk_addr_r;
    ignored_nxt  = ignored_r;
    out_vld_nxt  = out_vld_r;
    out_idx_nxt  = out_idx_r;
    out_none_nxt = out_none_r;
    out_ign_nxt  = out_ign_r;
    ram_we       = 1'b0;
    ram_waddr    = '0;
    ram_wdata    = '0;
    ram_re       = 1'b0;
    ram_raddr    = '0;
    scan_ctl     = '0;

    // Drop a taken result word
    if (out_vld_r && out_ch.ready) begin
      out_vld_nxt = 1'b0;
    end

    unique case (state_r)
      ST_CLR: begin
        ram_we      = 1'b1;
        ram_waddr   = clr_cnt_r[AW-1:0];
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CNT_W'(POOL_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_ch.mode)
            lda_pkg::MODE_ENTRY: begin
              ram_re       = 1'b1;
              ram_raddr    = AW'(in_ch.resource_index);
              upd_addr_nxt = AW'(in_ch.resource_index);
              upd_ok_nxt   = in_range;
              upd_last_nxt = in_ch.last_entry;
              state_nxt    = ST_UPD;
            end
            lda_pkg::MODE_EMPTY: begin
              scan_ctl.clr = 1'b1;
              scan_cnt_nxt = '0;
              chk_vld_nxt  = 1'b0;
              state_nxt    = ST_SCAN;
            end
            lda_pkg::MODE_CLEAR: begin
              clr_cnt_nxt = '0;
              ignored_nxt = 1'b0;
              state_nxt   = ST_CLR;
            end
            default: begin
              state_nxt = ST_IDLE;
            end
          endcase
        end
      end
      ST_UPD: begin
        // In range: write back the raised count and mark acceptable; else flag ignored
        if (upd_ok_r) begin
          ram_we    = 1'b1;
          ram_waddr = upd_addr_r;
          ram_wdata = {cnt_inc, rd_granted, 1'b1};
        end else begin
          ignored_nxt = 1'b1;
        end
        if (upd_last_r) begin
          scan_ctl.clr = 1'b1;
          scan_cnt_nxt = '0;
          chk_vld_nxt  = 1'b0;
          state_nxt    = ST_SCAN;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Issue the next read until the whole pool has been walked
        if (scan_cnt_r != CNT_W'(POOL_DEPTH)) begin
          ram_re       = 1'b1;
          ram_raddr    = scan_cnt_r[AW-1:0];
          scan_cnt_nxt = scan_cnt_r + 1'b1;
          chk_vld_nxt  = 1'b1;
          chk_addr_nxt = scan_cnt_r[AW-1:0];
        end else begin
          chk_vld_nxt = 1'b0;
          state_nxt   = ST_GRANT;
        end
        // Check the returned entry and clear its acceptable mark
        if (chk_vld_r) begin
          ram_we        = 1'b1;
          ram_waddr     = chk_addr_r;
          ram_wdata     = {rd_count, rd_granted, 1'b0};
          scan_ctl.take = rd_acc && !rd_granted && chk_in_range;
        end
      end
      ST_GRANT: begin
        // Hold until the result register is free
        if (!out_vld_r || out_ch.ready) begin
          out_vld_nxt  = 1'b1;
          out_idx_nxt  = best_found ? lda_pkg::IDX_W'(best_addr) : '0;
          out_none_nxt = !best_found;
          out_ign_nxt  = ignored_r;
          ignored_nxt  = 1'b0;
          if (best_found) begin
            ram_we    = 1'b1;
            ram_waddr = best_addr;
            ram_wdata = {best_count, 1'b1, 1'b0};
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLR;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_cnt_r   <= '0;
      scan_cnt_r  <= '0;
      upd_ok_r    <= 1'b0;
      upd_last_r  <= 1'b0;
      chk_vld_r   <= 1'b0;
      ignored_r   <= 1'b0;
      pool_size_r <= lda_pkg::SIZE_RESET;
      out_vld_r   <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      upd_ok_r   <= upd_ok_nxt;
      upd_last_r <= upd_last_nxt;
      chk_vld_r  <= chk_vld_nxt;
      ignored_r  <= ignored_nxt;
      out_vld_r  <= out_vld_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        pool_size_r <= cfg_ch.pool_size;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    upd_addr_r <= upd_addr_nxt;
    chk_addr_r <= chk_addr_nxt;
    out_idx_r  <= out_idx_nxt;
    out_none_r <= out_none_nxt;
    out_ign_r  <= out_ign_nxt;
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.granted_index  = out_idx_r;
  assign out_ch.none_available = out_none_r;
  assign out_ch.index_ignored  = out_ign_r;

  // Read and write never hit the same entry in one cycle, so no forwarding is needed
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
    else $error("pool memory read and write collide");

  // No input word is taken during the clearing pass
  a_clr_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLR) |-> !in_ch.ready)
    else $error("input accepted while clearing");

  // Scan address stays within the pool
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_cnt_r <= CNT_W'(POOL_DEPTH)))
    else $error("scan counter past pool depth");

  // A new result is loaded only into a free or draining output register
  a_no_result_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GRANT && out_vld_r && !out_ch.ready) |=> (state_r == ST_GRANT))
    else $error("grant left while result register was full");

  // Nothing granted means a zero index
  a_none_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.none_available) |-> (out_ch.granted_index == '0))
    else $error("nonzero index with none available");

endmodule
